### design/rhp_pkg.sv
// Shared constants, types and register codes for the ray / hexagonal prism
// intersection pipeline. No dependencies.
package rhp_pkg;

  // Fixed point format of all coordinates and distances
  localparam int FRAC_BITS = 16;

  // sqrt(3)/2 held as round(s * 2^30)
  localparam logic [29:0] KS3_Q30 = 30'd929887697;
  localparam int ONE_SHIFT  = 30;
  localparam int HALF_SHIFT = 29;

  // Datapath widths
  localparam int CRD_W = 32;            // input and register coordinate
  localparam int REL_W = CRD_W + 1;     // origin minus center
  localparam int DOT_W = 65;            // scaled dot product
  localparam int NUM_W = DOT_W + 1;     // slab numerator
  localparam int DEN_W = DOT_W - 1;     // magnitude of scaled denominator
  localparam int QUO_W = 32;            // quotient bits incl. overflow bit
  localparam int CMP_W = DEN_W + QUO_W; // divider remainder width

  // Pipeline shape
  localparam int FRONT_STAGES = 4;
  localparam int DIV_STAGES   = 8;
  localparam int DIV_BPS      = QUO_W / DIV_STAGES;
  localparam int RED_STAGES   = 3;
  localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + RED_STAGES;
  localparam int SLABS        = 4;
  localparam int LANES        = 2 * SLABS;

  localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] T_MAX = 32'sh7FFF_FFFF;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CENTER_Z    = 3'd2,
    REG_APOTHEM     = 3'd3,
    REG_HALF_HEIGHT = 3'd4
  } cfg_reg_t;

  typedef logic signed [DOT_W-1:0] sdot_t;
  typedef logic signed [NUM_W-1:0] snum_t;

  // Prism configuration as seen by the datapath
  typedef struct packed {
    logic signed [CRD_W-1:0] center_x;
    logic signed [CRD_W-1:0] center_y;
    logic signed [CRD_W-1:0] center_z;
    logic [CRD_W-2:0]        apothem;
    logic [CRD_W-2:0]        half_height;
  } cfg_t;

  // One division job: magnitudes, result sign and parallel-slab flag
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             par;
  } div_in_t;

endpackage

### design/rhp_front.sv
// Front end: relative origin, scaled dot products and division operands.
// Depends on rhp_pkg.
module rhp_front (
  input  logic                                clk,
  input  logic [rhp_pkg::FRONT_STAGES-1:0]    en,
  input  rhp_pkg::cfg_t                       cfg,
  input  logic signed [rhp_pkg::CRD_W-1:0]    origin_x,
  input  logic signed [rhp_pkg::CRD_W-1:0]    origin_y,
  input  logic signed [rhp_pkg::CRD_W-1:0]    origin_z,
  input  logic signed [rhp_pkg::CRD_W-1:0]    dir_x,
  input  logic signed [rhp_pkg::CRD_W-1:0]    dir_y,
  input  logic signed [rhp_pkg::CRD_W-1:0]    dir_z,
  output rhp_pkg::div_in_t [rhp_pkg::LANES-1:0] div_in
);

  // Stage 0: origin relative to center
  logic signed [rhp_pkg::REL_W-1:0] rx0, ry0, rz0;
  logic signed [rhp_pkg::CRD_W-1:0] dx0, dy0, dz0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rx0 <= rhp_pkg::REL_W'(origin_x) - rhp_pkg::REL_W'(cfg.center_x);
      ry0 <= rhp_pkg::REL_W'(origin_y) - rhp_pkg::REL_W'(cfg.center_y);
      rz0 <= rhp_pkg::REL_W'(origin_z) - rhp_pkg::REL_W'(cfg.center_z);
      dx0 <= dir_x;
      dy0 <= dir_y;
      dz0 <= dir_z;
    end
  end

  // Stage 1: z terms times sqrt(3)/2
  logic signed [rhp_pkg::REL_W-1:0]      rx1, ry1;
  logic signed [rhp_pkg::CRD_W-1:0]      dx1, dy1;
  logic signed [rhp_pkg::REL_W+30:0]     rzk1;
  logic signed [rhp_pkg::CRD_W+30:0]     dzk1;
  logic signed [30:0]                    ks3;

  assign ks3 = $signed({1'b0, rhp_pkg::KS3_Q30});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rx1  <= rx0;
      ry1  <= ry0;
      dx1  <= dx0;
      dy1  <= dy0;
      rzk1 <= rz0 * ks3;
      dzk1 <= dz0 * ks3;
    end
  end

  // Stage 2: dot products with the four slab normals
  rhp_pkg::sdot_t p2 [rhp_pkg::SLABS];
  rhp_pkg::sdot_t d2 [rhp_pkg::SLABS];
  rhp_pkg::sdot_t rxe, rye, rzke, dxe, dye, dzke;

  always_comb begin
    rxe  = rhp_pkg::DOT_W'(rx1);
    rye  = rhp_pkg::DOT_W'(ry1);
    rzke = rhp_pkg::DOT_W'(rzk1);
    dxe  = rhp_pkg::DOT_W'(dx1);
    dye  = rhp_pkg::DOT_W'(dy1);
    dzke = rhp_pkg::DOT_W'(dzk1);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p2[0] <= rxe <<< rhp_pkg::ONE_SHIFT;
      p2[1] <= (rxe <<< rhp_pkg::HALF_SHIFT) + rzke;
      p2[2] <= rzke - (rxe <<< rhp_pkg::HALF_SHIFT);
      p2[3] <= rye <<< rhp_pkg::ONE_SHIFT;
      d2[0] <= dxe <<< rhp_pkg::ONE_SHIFT;
      d2[1] <= (dxe <<< rhp_pkg::HALF_SHIFT) + dzke;
      d2[2] <= dzke - (dxe <<< rhp_pkg::HALF_SHIFT);
      d2[3] <= dye <<< rhp_pkg::ONE_SHIFT;
    end
  end

  // Stage 3: slab numerators, magnitudes and signs
  rhp_pkg::div_in_t [rhp_pkg::LANES-1:0] div_next;

  always_comb begin
    rhp_pkg::snum_t hw, pe, na, nb;
    rhp_pkg::sdot_t da;
    for (int k = 0; k < rhp_pkg::SLABS; k++) begin
      hw = (k == rhp_pkg::SLABS - 1) ? rhp_pkg::NUM_W'({1'b0, cfg.half_height})
                                     : rhp_pkg::NUM_W'({1'b0, cfg.apothem});
      hw = hw <<< rhp_pkg::ONE_SHIFT;
      pe = rhp_pkg::NUM_W'(p2[k]);
      na = hw - pe;
      nb = -hw - pe;
      da = d2[k][rhp_pkg::DOT_W-1] ? -d2[k] : d2[k];
      div_next[2*k].num   = na[rhp_pkg::NUM_W-1] ? -na : na;
      div_next[2*k+1].num = nb[rhp_pkg::NUM_W-1] ? -nb : nb;
      div_next[2*k].den   = da[rhp_pkg::DEN_W-1:0];
      div_next[2*k+1].den = da[rhp_pkg::DEN_W-1:0];
      div_next[2*k].neg   = na[rhp_pkg::NUM_W-1] ^ d2[k][rhp_pkg::DOT_W-1];
      div_next[2*k+1].neg = nb[rhp_pkg::NUM_W-1] ^ d2[k][rhp_pkg::DOT_W-1];
      div_next[2*k].par   = (d2[k] == '0);
      div_next[2*k+1].par = (d2[k] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      div_in <= div_next;
    end
  end

endmodule

### design/rhp_div_lane.sv
// Pipelined restoring divider lane: saturated signed Q quotient of one slab.
// Depends on rhp_pkg.
module rhp_div_lane (
  input  logic                            clk,
  input  logic [rhp_pkg::DIV_STAGES-1:0]  en,
  input  rhp_pkg::div_in_t                din,
  output logic signed [31:0]              res,
  output logic                            par
);

  logic [rhp_pkg::CMP_W-1:0] rem      [rhp_pkg::DIV_STAGES];
  logic [rhp_pkg::QUO_W-1:0] quo      [rhp_pkg::DIV_STAGES];
  logic [rhp_pkg::DEN_W-1:0] den      [rhp_pkg::DIV_STAGES];
  logic                      neg      [rhp_pkg::DIV_STAGES];
  logic                      par_s    [rhp_pkg::DIV_STAGES];
  logic [rhp_pkg::CMP_W-1:0] rem_next [rhp_pkg::DIV_STAGES];
  logic [rhp_pkg::QUO_W-1:0] quo_next [rhp_pkg::DIV_STAGES];

  // Resolve DIV_BPS quotient bits per stage, overflow bit first
  always_comb begin
    logic [rhp_pkg::CMP_W-1:0] r, trial;
    logic [rhp_pkg::QUO_W-1:0] q;
    logic [rhp_pkg::DEN_W-1:0] dv;
    for (int s = 0; s < rhp_pkg::DIV_STAGES; s++) begin
      if (s == 0) begin
        r  = rhp_pkg::CMP_W'(din.num) << rhp_pkg::FRAC_BITS;
        q  = '0;
        dv = din.den;
      end else begin
        r  = rem[s-1];
        q  = quo[s-1];
        dv = den[s-1];
      end
      for (int b = 0; b < rhp_pkg::DIV_BPS; b++) begin
        trial = rhp_pkg::CMP_W'(dv) << (rhp_pkg::QUO_W - 1 - s * rhp_pkg::DIV_BPS - b);
        if (r >= trial) begin
          r = r - trial;
          q[rhp_pkg::QUO_W - 1 - s * rhp_pkg::DIV_BPS - b] = 1'b1;
        end
      end
      rem_next[s] = r;
      quo_next[s] = q;
    end
  end

  // Advance each stage on its own enable
  always_ff @(posedge clk) begin
    for (int s = 0; s < rhp_pkg::DIV_STAGES; s++) begin
      if (en[s]) begin
        rem[s] <= rem_next[s];
        quo[s] <= quo_next[s];
        if (s == 0) begin
          den[s]   <= din.den;
          neg[s]   <= din.neg;
          par_s[s] <= din.par;
        end else begin
          den[s]   <= den[s-1];
          neg[s]   <= neg[s-1];
          par_s[s] <= par_s[s-1];
        end
      end
    end
  end

  // Saturate and apply sign
  logic [31:0] mag;

  assign mag = {1'b0, quo[rhp_pkg::DIV_STAGES-1][rhp_pkg::QUO_W-2:0]};
  assign par = par_s[rhp_pkg::DIV_STAGES-1];

  always_comb begin
    if (quo[rhp_pkg::DIV_STAGES-1][rhp_pkg::QUO_W-1]) begin
      res = neg[rhp_pkg::DIV_STAGES-1] ? rhp_pkg::T_MIN : rhp_pkg::T_MAX;
    end else if (neg[rhp_pkg::DIV_STAGES-1]) begin
      res = $signed(-mag);
    end else begin
      res = $signed(mag);
    end
  end

endmodule

### design/rhp_reduce.sv
// Back end: per-slab entry/exit ordering, near/far reduction and result register.
// Depends on rhp_pkg.
module rhp_reduce (
  input  logic                                  clk,
  input  logic [rhp_pkg::RED_STAGES-1:0]        en,
  input  logic [rhp_pkg::LANES-1:0][31:0]       res,
  input  logic [rhp_pkg::LANES-1:0]             par,
  output logic                                  hit,
  output logic signed [31:0]                    near_dist,
  output logic signed [31:0]                    far_dist,
  output logic                                  starts_inside,
  output logic [1:0]                            face_index
);

  // Stage 0: order entry and exit per slab
  logic signed [31:0] tin  [rhp_pkg::SLABS];
  logic signed [31:0] tout [rhp_pkg::SLABS];

  always_ff @(posedge clk) begin
    for (int k = 0; k < rhp_pkg::SLABS; k++) begin
      if (en[0]) begin
        if (par[2*k]) begin
          tin[k]  <= rhp_pkg::T_MIN;
          tout[k] <= rhp_pkg::T_MAX;
        end else if ($signed(res[2*k]) > $signed(res[2*k+1])) begin
          tin[k]  <= $signed(res[2*k+1]);
          tout[k] <= $signed(res[2*k]);
        end else begin
          tin[k]  <= $signed(res[2*k]);
          tout[k] <= $signed(res[2*k+1]);
        end
      end
    end
  end

  // Stage 1: pairwise max of entries (ties to lower face), min of exits
  logic signed [31:0] m01, m23, f01, f23;
  logic [1:0]         i01, i23;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (tin[0] >= tin[1]) begin
        m01 <= tin[0];
        i01 <= 2'd0;
      end else begin
        m01 <= tin[1];
        i01 <= 2'd1;
      end
      if (tin[2] >= tin[3]) begin
        m23 <= tin[2];
        i23 <= 2'd2;
      end else begin
        m23 <= tin[3];
        i23 <= 2'd3;
      end
      f01 <= (tout[0] < tout[1]) ? tout[0] : tout[1];
      f23 <= (tout[2] < tout[3]) ? tout[2] : tout[3];
    end
  end

  // Stage 2: final near/far and hit decision
  logic signed [31:0] tnear, tfar;
  logic [1:0]         face;
  logic               is_hit;

  always_comb begin
    if (m01 >= m23) begin
      tnear = m01;
      face  = i01;
    end else begin
      tnear = m23;
      face  = i23;
    end
    tfar   = (f01 < f23) ? f01 : f23;
    is_hit = (tnear <= tfar) && (tfar >= 32'sd0);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      hit           <= is_hit;
      near_dist     <= is_hit ? tnear : 32'sd0;
      far_dist      <= is_hit ? tfar : 32'sd0;
      starts_inside <= is_hit && (tnear <= 32'sd0);
      face_index    <= is_hit ? face : 2'd0;
    end
  end

endmodule

### design/ray_hex_prism_intersect.sv
// Ray / hexagonal prism slab intersection, top level.
// Pipeline: 15 register stages (4 front, 8 divider, 3 reduce); a result is offered
// once its ray has moved through all of them, and transfers while res_stall is low.
// Throughput: one ray per cycle while no stall holds the pipeline; every stage, the 8-stage
// divider with 4 quotient bits a stage included, takes a new item each cycle unless held.
// Stalls hold only the stages that are full, so bubbles close up under a stalled result.
// Reset (rst, synchronous): clears all valid bits, center to 0, apothem and half_height
// to 1.0; no clearing pass is needed.
module ray_hex_prism_intersect (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rhp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              ray_valid,
  output logic                              ray_stall,
  input  logic signed [31:0]                origin_x,
  input  logic signed [31:0]                origin_y,
  input  logic signed [31:0]                origin_z,
  input  logic signed [31:0]                dir_x,
  input  logic signed [31:0]                dir_y,
  input  logic signed [31:0]                dir_z,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic                              hit,
  output logic signed [31:0]                near_dist,
  output logic signed [31:0]                far_dist,
  output logic                              starts_inside,
  output logic [1:0]                        face_index
);

  localparam int LAST = rhp_pkg::PIPE_STAGES - 1;
  localparam int DIV0 = rhp_pkg::FRONT_STAGES;
  localparam int RED0 = rhp_pkg::FRONT_STAGES + rhp_pkg::DIV_STAGES;

  // Configuration registers
  rhp_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x    <= '0;
      cfg.center_y    <= '0;
      cfg.center_z    <= '0;
      cfg.apothem     <= 31'd65536;
      cfg.half_height <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (rhp_pkg::cfg_reg_t'(cfg_index))
        rhp_pkg::REG_CENTER_X:    cfg.center_x    <= $signed(cfg_data);
        rhp_pkg::REG_CENTER_Y:    cfg.center_y    <= $signed(cfg_data);
        rhp_pkg::REG_CENTER_Z:    cfg.center_z    <= $signed(cfg_data);
        rhp_pkg::REG_APOTHEM:     cfg.apothem     <= cfg_data[30:0];
        rhp_pkg::REG_HALF_HEIGHT: cfg.half_height <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when its successor moves
  logic [rhp_pkg::PIPE_STAGES-1:0] v;
  logic [rhp_pkg::PIPE_STAGES-1:0] en;

  always_comb begin
    en[LAST] = !v[LAST] || !res_stall;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign ray_stall = !en[0];
  assign res_valid = v[LAST];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= ray_valid;
      end
      for (int i = 1; i < rhp_pkg::PIPE_STAGES; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Datapath
  rhp_pkg::div_in_t [rhp_pkg::LANES-1:0] div_in;
  logic [rhp_pkg::LANES-1:0][31:0]       div_res;
  logic [rhp_pkg::LANES-1:0]             div_par;

  rhp_front u_front (
    .clk      (clk),
    .en       (en[rhp_pkg::FRONT_STAGES-1:0]),
    .cfg      (cfg),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .origin_z (origin_z),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z),
    .div_in   (div_in)
  );

  for (genvar l = 0; l < rhp_pkg::LANES; l++) begin : g_lane
    rhp_div_lane u_div (
      .clk (clk),
      .en  (en[DIV0 +: rhp_pkg::DIV_STAGES]),
      .din (div_in[l]),
      .res (div_res[l]),
      .par (div_par[l])
    );
  end

  rhp_reduce u_reduce (
    .clk           (clk),
    .en            (en[RED0 +: rhp_pkg::RED_STAGES]),
    .res           (div_res),
    .par           (div_par),
    .hit           (hit),
    .near_dist     (near_dist),
    .far_dist      (far_dist),
    .starts_inside (starts_inside),
    .face_index    (face_index)
  );

`ifndef SYNTHESIS
  // Input held back only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    ray_stall |-> (&v))
    else $error("ray stalled with an empty stage");

  // An accepted ray occupies the first stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (ray_valid && !ray_stall) |=> v[0])
    else $error("accepted ray lost at stage 0");

  // Miss results carry all-zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !hit) |-> (near_dist == 32'sd0 && far_dist == 32'sd0 &&
                             face_index == 2'd0 && !starts_inside))
    else $error("miss result with nonzero payload");

  // Hit results are ordered
  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    (res_valid && hit) |-> (near_dist <= far_dist && far_dist >= 32'sd0))
    else $error("hit with near beyond far");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for ray_hex_prism_intersect: directed and random rays
// under several prism settings, with results checked against a built-in predictor.
// Depends on rhp_pkg and the ray_hex_prism_intersect RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rhp_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] near_t;
    logic signed [31:0] far_t;
    logic               starts_in;
    logic [1:0]         face;
  } isect_t;

  // Scoreboard: prism registers, predictor and queue of expected intersections
  class isect_scoreboard;
    logic signed [31:0] cx, cy, cz;
    logic [30:0]        apo, hh;
    isect_t             expected_q[$];
    int                 errors;

    function new();
      cx = 0; cy = 0; cz = 0; apo = 31'd65536; hh = 31'd65536; errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_CENTER_X:    cx = data;
        REG_CENTER_Y:    cy = data;
        REG_CENTER_Z:    cz = data;
        REG_APOTHEM:     apo = data[30:0];
        REG_HALF_HEIGHT: hh = data[30:0];
        default: ;
      endcase
    endfunction

    // Dot product with slab normal, scaled by 2^30
    function wide_t slab_dot(int k, wide_t x, wide_t y, wide_t z);
      wide_t s3;
      s3 = 929887697;
      case (k)
        0: return x <<< 30;
        1: return (x <<< 29) + z * s3;
        2: return z * s3 - (x <<< 29);
        default: return y <<< 30;
      endcase
    endfunction

    // Truncating quotient in Q16.16, saturated to 32 bits
    function logic signed [31:0] slab_div(wide_t num, wide_t den);
      logic  neg;
      wide_t an, ad, q;
      neg = (num < 0) != (den < 0);
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      if (an / ad >= (128'sd1 <<< (31 - FRAC_BITS)))
        return neg ? T_MIN : T_MAX;
      q = (an <<< FRAC_BITS) / ad;
      return neg ? 32'(-q) : 32'(q);
    endfunction

    function void note_ray(ray_t r);
      wide_t rx, ry, rz, den, d, p;
      logic signed [31:0] a, b, t, t_near, t_far;
      logic signed [31:0] entry[4];
      isect_t e;
      rx = wide_t'(r.ox) - wide_t'(cx);
      ry = wide_t'(r.oy) - wide_t'(cy);
      rz = wide_t'(r.oz) - wide_t'(cz);
      t_near = T_MIN;
      t_far = T_MAX;
      for (int k = 0; k < SLABS; k++) begin
        den = slab_dot(k, r.dx, r.dy, r.dz);
        if (den == 0) begin
          a = T_MIN;
          b = T_MAX;
        end else begin
          d = (k == 3) ? (wide_t'(hh) <<< 30) : (wide_t'(apo) <<< 30);
          p = slab_dot(k, rx, ry, rz);
          a = slab_div(d - p, den);
          b = slab_div(-d - p, den);
          if (a > b) begin
            t = a; a = b; b = t;
          end
        end
        entry[k] = a;
        if (a > t_near) t_near = a;
        if (b < t_far) t_far = b;
      end
      e = '{hit: 1'b0, near_t: 0, far_t: 0, starts_in: 1'b0, face: 2'd0};
      if (!(t_near > t_far || t_far < 0)) begin
        e.hit = 1'b1;
        e.near_t = t_near;
        e.far_t = t_far;
        e.starts_in = t_near <= 0;
        for (int k = SLABS - 1; k >= 0; k--)
          if (entry[k] == t_near) e.face = k;
      end
      expected_q.push_back(e);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(isect_t got);
      isect_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, hit", got.hit, 0);
        return;
      end
      e = expected_q.pop_front();
      if (got.hit !== e.hit) report_mismatch("hit", got.hit, e.hit);
      if (got.near_t !== e.near_t) report_mismatch("near_dist", got.near_t, e.near_t);
      if (got.far_t !== e.far_t) report_mismatch("far_dist", got.far_t, e.far_t);
      if (got.starts_in !== e.starts_in)
        report_mismatch("starts_inside", got.starts_in, e.starts_in);
      if (got.face !== e.face) report_mismatch("face_index", got.face, e.face);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic ray_valid = 1'b0;
  logic ray_stall;
  logic signed [31:0] origin_x = 0, origin_y = 0, origin_z = 0;
  logic signed [31:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic hit, starts_inside;
  logic signed [31:0] near_dist, far_dist;
  logic [1:0] face_index;

  isect_scoreboard sb = new();
  bit hold_req = 0;
  int idle_cycles = 0;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  ray_hex_prism_intersect dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      sb.check_result('{hit, near_dist, far_dist, starts_inside, face_index});
  end

  // Watchdog: end the run if nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (ray_valid && !ray_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result stall pattern, with a long hold-off on request
  initial begin
    int mode;
    forever begin
      if (hold_req) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          res_stall = 1'b1;
        end
        hold_req = 0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(8, 64)) begin
        @(negedge clk);
        case (mode)
          0: res_stall = 1'b0;
          1: res_stall = $urandom_range(0, 1);
          2: res_stall = ($urandom_range(0, 2) == 0);
          default: res_stall = ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offer one ray at the falling edge and hold it until the transfer
  task automatic send_ray(ray_t r);
    @(negedge clk);
    ray_valid = 1'b1;
    {origin_x, origin_y, origin_z} = {r.ox, r.oy, r.oz};
    {dir_x, dir_y, dir_z} = {r.dx, r.dy, r.dz};
    do @(posedge clk); while (ray_stall);
    sb.note_ray(r);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    ray_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain();
    pause_sender(1);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_near(logic signed [31:0] base, int span);
    return base + ($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [31:0] rand_dir(int span);
    if ($urandom_range(0, 5) == 0) return 0;
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  // Random ray: mostly aimed near the prism, some full-range noise
  function automatic ray_t make_ray();
    ray_t r;
    int reach, sel;
    reach = (sb.apo > 31'd2000000) ? 4000000 : 4 * int'(sb.apo) + 65536;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      r.ox = rand_near(sb.cx, reach);
      r.oy = rand_near(sb.cy, reach);
      r.oz = rand_near(sb.cz, reach);
      r.dx = rand_dir(200000);
      r.dy = rand_dir(200000);
      r.dz = rand_dir(200000);
    end else if (sel < 8) begin
      r = '{$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    end else begin
      r.ox = rand_near(sb.cx, reach);
      r.oy = rand_near(sb.cy, reach);
      r.oz = rand_near(sb.cz, reach);
      r.dx = $urandom_range(0, 1) ? $urandom() : 0;
      r.dy = $urandom_range(0, 1) ? $urandom() : 0;
      r.dz = $urandom_range(0, 1) ? $urandom() : 0;
    end
    return r;
  endfunction

  task automatic random_rays(int count);
    int left;
    left = count;
    while (left > 0) begin
      for (int n = $urandom_range(1, 40); n > 0 && left > 0; n--) begin
        send_ray(make_ray());
        left--;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
  endtask

  task automatic program_prism(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] a, logic [31:0] h);
    write_reg(REG_CENTER_X, x);
    write_reg(REG_CENTER_Y, y);
    write_reg(REG_CENTER_Z, z);
    write_reg(REG_APOTHEM, a);
    write_reg(REG_HALF_HEIGHT, h);
    // index past the last register must be ignored
    write_reg(CFG_IDX_W'(REG_HALF_HEIGHT) + CFG_IDX_W'($urandom_range(1, 3)), $urandom());
    @(negedge clk);
  endtask

  initial begin
    ray_t directed[$];
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed rays under the reset prism
    directed = '{
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh80000000},
      '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF},
      '{0, 0, 0, 0, 0, 0},
      '{32'sh7FFFFFFF, 5, -7, 0, 0, 0},
      '{-32'sd196608, 0, 0, 65536, 0, 0},
      '{0, -32'sd196608, 0, 0, 65536, 0},
      '{0, 0, -32'sd196608, 0, 0, 65536},
      '{0, 0, 0, 65536, 0, 0},
      '{0, 0, 0, 0, -65536, 0},
      '{32'sd196608, 0, 0, 65536, 0, 0},
      '{32'sd196608, 0, 0, -65536, 0, 0},
      '{0, 0, 0, -929887697, 0, 32'sh20000000},
      '{0, 0, 0, 929887697, 0, 32'sh20000000},
      '{-32'sd196608, 0, 32'sd50000, -929887697, 0, 32'sh20000000},
      '{32'sd65536, 0, 0, 1, 0, 0},
      '{0, 32'sd65536, 0, 0, 1, 0},
      '{0, 0, 0, 1, 1, 1},
      '{-32'sd131072, -32'sd131072, -32'sd131072, 65536, 65536, 65536},
      '{-32'sd131072, 32'sd500000, 0, 65536, 0, 0},
      '{32'sh7FFFFFFF, 0, 0, 32'sh80000000, 0, 0},
      '{0, 0, 0, 32'sh80000000, 32'sh7FFFFFFF, 1}
    };
    foreach (directed[i]) send_ray(directed[i]);
    random_rays(120);

    // Let results back up behind a long receiver hold-off
    hold_req = 1;
    random_rays(60);
    drain();

    program_prism(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
    random_rays(110);
    drain();
    program_prism(32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
    random_rays(110);
    drain();
    program_prism(0, 0, 0, 32'h80000000, 32'h7FFFFFFF);
    random_rays(110);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      program_prism(rand_near(0, 655360), rand_near(0, 655360), rand_near(0, 655360),
                    $urandom_range(32768, 524288), $urandom_range(0, 524288));
      random_rays(100);
      drain();
    end
    program_prism($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    random_rays(80);
    drain();

    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
design/rhp_pkg.sv
design/rhp_front.sv
design/rhp_div_lane.sv
design/rhp_reduce.sv
design/ray_hex_prism_intersect.sv
tb/testbench.sv
